// ===== rtl/core/dtf_pkg.sv =====
package dtf_pkg;

  localparam int FracDigits = 9;
  localparam int FracBits   = 28;

  localparam int ChW      = 8;
  localparam int IntW     = 8;
  localparam int DigitW   = 4;
  localparam int FracAccW = FracBits + 1;
  localparam int CntW     = $clog2(FracDigits + 1);
  localparam int ValueW   = 32;
  localparam int LimitW   = 31;
  localparam int StatusW  = 2;
  localparam int SumW     = (IntW + FracBits + 1 > ValueW + 1) ? IntW + FracBits + 1 : ValueW + 1;

  // round(2^FracBits / 10^k) as (2^(FracBits+1) / 10^k + 1) / 2
  localparam longint unsigned WeightNum = 64'd1 << (FracBits + 1);
  localparam logic [FracBits-1:0] FracWeight [2**CntW] = '{
    FracBits'(0),
    FracBits'((WeightNum / 64'd10 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd100 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd1000 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd10000 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd100000 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd1000000 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd10000000 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd100000000 + 64'd1) / 64'd2),
    FracBits'((WeightNum / 64'd1000000000 + 64'd1) / 64'd2),
    FracBits'(0), FracBits'(0), FracBits'(0), FracBits'(0), FracBits'(0), FracBits'(0)
  };

  typedef enum logic [2:0] {
    TkBlank,
    TkSign,
    TkDigit,
    TkPoint,
    TkNul,
    TkOther
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e         kind;
    logic              neg;
    logic [DigitW-1:0] digit;
  } token_t;

  typedef enum logic [4:0] {
    PhBlank  = 5'b00001,
    PhSigned = 5'b00010,
    PhInt    = 5'b00100,
    PhFrac   = 5'b01000,
    PhErr    = 5'b10000
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StNoDigit = 2'd1,
    StBadInt  = 2'd2,
    StBadFrac = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CfgClampLimit  = 1'b0,
    CfgClampEnable = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [LimitW-1:0] limit;
    logic              enable;
  } cfg_t;

endpackage

// ===== rtl/core/dtf_front.sv =====
module dtf_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [dtf_pkg::ChW-1:0] ch_i,
  output logic                    tok_valid_o,
  input  logic                    tok_ready_i,
  output dtf_pkg::token_t         tok_o
);
  import dtf_pkg::*;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChCr    = 8'h0D;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChPoint = 8'h2E;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;

  logic   valid_q;
  token_t tok_q;
  token_t tok_d;
  logic   accept;

  assign in_ready_o  = !valid_q || tok_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

  always_comb begin
    tok_d.neg   = (ch_i == ChMinus);
    tok_d.digit = DigitW'(ch_i - ChZero);
    if (ch_i == ChNul) begin
      tok_d.kind = TkNul;
    end else if (ch_i == ChSpace || (ch_i inside {[ChTab:ChCr]})) begin
      tok_d.kind = TkBlank;
    end else if (ch_i == ChMinus || ch_i == ChPlus) begin
      tok_d.kind = TkSign;
    end else if (ch_i inside {[ChZero:ChNine]}) begin
      tok_d.kind = TkDigit;
    end else if (ch_i == ChPoint) begin
      tok_d.kind = TkPoint;
    end else begin
      tok_d.kind = TkOther;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (tok_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q <= tok_d;
    end
  end

endmodule

// ===== rtl/core/dtf_fifo.sv =====
module dtf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  dtf_pkg::token_t push_tok_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output dtf_pkg::token_t pop_tok_o
);
  import dtf_pkg::*;

  token_t     slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_tok_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// ===== rtl/core/dtf_back.sv =====
module dtf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dtf_pkg::cfg_t               cfg_i,
  input  logic                        tok_valid_i,
  output logic                        tok_ready_o,
  input  dtf_pkg::token_t             tok_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dtf_pkg::ValueW-1:0]  value_o,
  output logic [dtf_pkg::StatusW-1:0] status_o
);
  import dtf_pkg::*;

  // parse state
  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [IntW-1:0]     int_q, int_d;
  logic [FracAccW-1:0] frac_q, frac_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  status_e             err_q, err_d;

  // stage 1: finished number
  logic                s1_valid_q;
  logic                s1_neg_q;
  logic [IntW-1:0]     s1_int_q;
  logic [FracAccW-1:0] s1_frac_q;
  status_e             s1_st_q, s1_st_d;

  // stage 2: saturated magnitude
  logic                s2_valid_q;
  logic                s2_neg_q;
  logic [ValueW-1:0]   s2_mag_q, s2_mag_d;
  status_e             s2_st_q;

  // output register
  logic                out_valid_q;
  logic [ValueW-1:0]   value_q, value_d;
  status_e             status_q;

  logic                out_free, s2_free, s1_free;
  logic                pop, emit;
  logic [IntW+3:0]     int_next;
  logic [SumW-1:0]     sum;
  logic [ValueW-1:0]   lim;
  logic [ValueW-1:0]   mag_clamped;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s2_free     = !s2_valid_q || out_free;
  assign s1_free     = !s1_valid_q || s2_free;
  assign tok_ready_o = (tok_i.kind != TkNul) || s1_free;
  assign pop         = tok_valid_i && tok_ready_o;
  assign emit        = pop && (tok_i.kind == TkNul);

  assign int_next = ((IntW + 4)'(int_q) * (IntW + 4)'(10)) + (IntW + 4)'(tok_i.digit);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    if (pop) begin
      if (tok_i.kind == TkNul) begin
        phase_d = PhBlank;
        neg_d   = 1'b0;
        int_d   = '0;
        frac_d  = '0;
        cnt_d   = '0;
        err_d   = StOk;
      end else begin
        case (phase_q)
          PhBlank: begin
            if (tok_i.kind == TkBlank) begin
              phase_d = PhBlank;
            end else if (tok_i.kind == TkSign) begin
              neg_d   = tok_i.neg;
              phase_d = PhSigned;
            end else if (tok_i.kind == TkDigit) begin
              int_d   = IntW'(tok_i.digit);
              phase_d = PhInt;
            end else begin
              err_d   = StNoDigit;
              phase_d = PhErr;
            end
          end
          PhSigned: begin
            if (tok_i.kind == TkDigit) begin
              int_d   = IntW'(tok_i.digit);
              phase_d = PhInt;
            end else begin
              err_d   = StNoDigit;
              phase_d = PhErr;
            end
          end
          PhInt: begin
            if (tok_i.kind == TkDigit) begin
              int_d = (int_next > (IntW + 4)'(2**IntW - 1)) ? '1 : int_next[IntW-1:0];
            end else if (tok_i.kind == TkPoint) begin
              phase_d = PhFrac;
            end else begin
              err_d   = StBadInt;
              phase_d = PhErr;
            end
          end
          PhFrac: begin
            if (tok_i.kind == TkDigit) begin
              if (cnt_q < CntW'(FracDigits)) begin
                cnt_d  = cnt_q + CntW'(1);
                frac_d = frac_q + FracAccW'(tok_i.digit * FracWeight[cnt_q + CntW'(1)]);
              end
            end else begin
              err_d   = StBadFrac;
              phase_d = PhErr;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_comb begin
    case (phase_q)
      PhBlank, PhSigned: s1_st_d = StNoDigit;
      PhInt, PhFrac:     s1_st_d = StOk;
      default:           s1_st_d = err_q;
    endcase
  end

  // combine integer and fraction, saturate to the signed 32-bit range
  assign sum = (SumW'(s1_int_q) << FracBits) + SumW'(s1_frac_q);
  always_comb begin
    if (s1_neg_q) begin
      s2_mag_d = (sum > SumW'(33'h080000000)) ? 32'h80000000 : sum[ValueW-1:0];
    end else begin
      s2_mag_d = (sum > SumW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : sum[ValueW-1:0];
    end
  end

  // symmetric clamp acts on the magnitude, then apply the sign
  assign lim         = {1'b0, cfg_i.limit};
  assign mag_clamped = (cfg_i.enable && s2_mag_q > lim) ? lim : s2_mag_q;
  always_comb begin
    if (s2_st_q != StOk) begin
      value_d = '0;
    end else if (s2_neg_q) begin
      value_d = -mag_clamped;
    end else begin
      value_d = mag_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhBlank;
      neg_q       <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      cnt_q       <= '0;
      err_q       <= StOk;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      if (s1_free) begin
        s1_valid_q <= emit;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_neg_q  <= neg_q;
      s1_int_q  <= int_q;
      s1_frac_q <= frac_q;
      s1_st_q   <= s1_st_d;
    end
    if (s2_free && s1_valid_q) begin
      s2_neg_q <= s1_neg_q;
      s2_mag_q <= s2_mag_d;
      s2_st_q  <= s1_st_q;
    end
    if (out_free && s2_valid_q) begin
      value_q  <= value_d;
      status_q <= s2_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_err_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != StOk) |-> value_q == '0)
    else $error("failed parse delivered a nonzero value");

  a_frac_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FracDigits))
    else $error("fraction digit count past limit");

  a_err_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhErr) |-> (err_q != StOk))
    else $error("error phase without an error code");

  a_nul_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (phase_q == PhBlank) && (cnt_q == '0) && (frac_q == '0))
    else $error("parse state not cleared after terminator");

endmodule

// ===== rtl/core/decimal_text_to_fixed_clamped.sv =====
// Decimal text to signed fixed point (Q3.28) converter.
//
// Input channel (in_valid_i / in_ready_o / ch_i): one text byte per transfer.
// Leading blanks, optional sign, integer digits, optional point and fraction
// digits; a zero byte terminates the number and produces exactly one result.
// Output channel (out_valid_o / out_ready_i / value_o, status_o): one transfer
// per terminator, status 0 ok, 1 no leading digit, 2 bad char after the
// integer part, 3 bad char after the fraction; value is 0 on any error.
// Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): index 0 clamp_limit,
// index 1 clamp_enable; write only while no number is in flight.
// Throughput: one byte per cycle, sustained, including terminators, while
// the receiver takes results; a result passes the front register, token
// queue, parse stage, saturate stage and clamp/output register.
// Reset: parser back at leading blanks, pipeline empty, clamp 2.0 enabled.
// Receiver stall: the output register holds; the saturate and parse stages
// take two more results, then the next terminator waits at the queue head and
// the queue and front register back up until in_ready_o drops.
module decimal_text_to_fixed_clamped (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dtf_pkg::ChW-1:0]     ch_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dtf_pkg::ValueW-1:0]  value_o,
  output logic [dtf_pkg::StatusW-1:0] status_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [dtf_pkg::LimitW-1:0]  cfg_wdata_i
);
  import dtf_pkg::*;

  localparam logic [LimitW-1:0] ClampLimitReset = 31'd536870912;  // 2.0

  cfg_t   cfg_q;
  token_t front_tok;
  logic   front_valid, front_ready;
  token_t queue_tok;
  logic   queue_valid, queue_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit  <= ClampLimitReset;
      cfg_q.enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgClampLimit:  cfg_q.limit  <= cfg_wdata_i;
        CfgClampEnable: cfg_q.enable <= cfg_wdata_i[0];
        default:        cfg_q        <= cfg_q;
      endcase
    end
  end

  // front: takes bytes and classifies them into tokens
  dtf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .tok_valid_o (front_valid),
    .tok_ready_i (front_ready),
    .tok_o       (front_tok)
  );

  // decouples classification from parsing
  dtf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_tok_i   (front_tok),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_tok_o    (queue_tok)
  );

  // back: parse state, accumulation, saturation and clamp
  dtf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tok_valid_i (queue_valid),
    .tok_ready_o (queue_ready),
    .tok_i       (queue_tok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule
